@@ rtl/dht_pkg.sv @@
package dht_pkg;

  // Slot status codes held in the table memory.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_DEL   = 2'd2
  } slot_st_t;

  // Request operation codes. Code 3 carries no operation and only reports the total.
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_SEARCH = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [3:0] CFG_TABLE_SIZE  = 4'd0;
  localparam logic [3:0] CFG_HASH_SELECT = 4'd1;

  // Hash constants.
  localparam int unsigned HASH_MUL_A   = 17;
  localparam int unsigned HASH_MUL_B   = 29;
  localparam int unsigned HASH_OFFSET  = 44497;
  localparam int unsigned STEP_SEED    = 5381;
  localparam int unsigned STEP_SHIFT   = 5;
  localparam int unsigned TABLE_SIZE_RST = 1024;

endpackage

@@ rtl/dht_mod_unit.sv @@
module dht_mod_unit #(
  parameter int DW = 22,
  parameter int SW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x,
  input  logic [SW-1:0] modulus,
  output logic          busy,
  output logic [SW-1:0] rem
);

  localparam int STEPS = DW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] x_r;
  logic [SW-1:0] r_r;
  logic [SW:0]   r1, r2, m_ext;

  // Two restoring remainder steps per cycle, most significant bits first.
  always_comb begin
    m_ext = {1'b0, modulus};
    r1 = {r_r, x_r[DW-1]};
    if (r1 >= m_ext) begin
      r1 = r1 - m_ext;
    end
    r2 = {r1[SW-1:0], x_r[DW-2]};
    if (r2 >= m_ext) begin
      r2 = r2 - m_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      r_r <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 2;
      r_r <= r2[SW-1:0];
    end
  end

  assign busy = busy_r;
  assign rem  = r_r;

endmodule

@@ rtl/double_hashing_table_core.sv @@
// Double-hashing table core with one result per request.
// After reset a clearing pass marks every slot empty; no request is taken until it ends,
// while configuration writes are taken at any time.
// A request is hashed byte by byte through the two serial remainder units, and each
// probe passes through the PROBE and CHECK states around the registered memory read.
// Requests are handled one at a time; a finished result waits in the output register.
module double_hashing_table_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [3:0]  in_key_length,
  input  logic [30:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [9:0]  out_slot,
  output logic [10:0] out_probe_count,
  output logic [31:0] out_collision_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  import dht_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(TABLE_DEPTH + 1);
  localparam int DW0 = (SW + 6 > 16) ? SW + 6 : 16;
  localparam int DW  = DW0 + (DW0 % 2);
  localparam int MW  = 2 + 4 + 64 + 31;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_HASH  = 8'b0000_1000,
    S_BASE  = 8'b0001_0000,
    S_PROBE = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t        st_r, st_nxt;
  logic [10:0]   size_r;
  logic          hsel_r;
  logic [31:0]   coll_r, coll_nxt;
  logic [AW-1:0] clr_r;

  // Request registers.
  logic [1:0]    func_r;
  logic [63:0]   key_r;
  logic [3:0]    len_r;
  logic [30:0]   val_r;
  logic [3:0]    byte_r;
  logic          first_r;
  logic [SW-1:0] step_r, loc_r, i_r;

  // Result waiting for the output register.
  logic          res_hit_r;
  logic [SW-1:0] res_slot_r, res_i_r;

  logic          out_valid_r, out_hit_r;
  logic [9:0]    out_slot_r;
  logic [10:0]   out_probe_r;
  logic [31:0]   out_total_r;

  // Effective table size: zero reads as one, large values saturate at the depth.
  logic [31:0]   size_ext;
  logic [SW-1:0] t_eff;
  always_comb begin
    size_ext = 32'(size_r);
    if (size_ext == 32'd0) begin
      t_eff = SW'(1);
    end else if (size_ext > 32'(TABLE_DEPTH)) begin
      t_eff = SW'(TABLE_DEPTH);
    end else begin
      t_eff = size_ext[SW-1:0];
    end
  end

  // Key length saturation and masking at acceptance.
  logic [3:0]  len_sat;
  logic [63:0] key_mask;
  always_comb begin
    len_sat = (in_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_length;
    for (int b = 0; b < 8; b++) begin
      key_mask[8*b +: 8] = (4'(b) < len_sat) ? in_key[8*b +: 8] : 8'h00;
    end
  end

  // Two remainder units: one for the base hash, one for the step hash.
  logic          h_start, s_start, h_busy, s_busy;
  logic [DW-1:0] h_x, s_x;
  logic [SW-1:0] h_rem, s_rem;

  dht_mod_unit #(.DW(DW), .SW(SW)) u_hmod (
    .clk(clk), .rst_n(rst_n), .start(h_start), .x(h_x), .modulus(t_eff),
    .busy(h_busy), .rem(h_rem)
  );

  dht_mod_unit #(.DW(DW), .SW(SW)) u_smod (
    .clk(clk), .rst_n(rst_n), .start(s_start), .x(s_x), .modulus(t_eff),
    .busy(s_busy), .rem(s_rem)
  );

  // Table memory: status, length, key and value in one word.
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_r, wr_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[loc_r[AW-1:0]];
  end

  logic [1:0]  rd_st;
  logic [3:0]  rd_len;
  logic [63:0] rd_key;
  logic [30:0] rd_val;
  assign {rd_st, rd_len, rd_key, rd_val} = rd_r;

  logic        rd_used, rd_empty, rd_match;
  assign rd_used  = (rd_st == SLOT_USED);
  assign rd_empty = (rd_st == SLOT_EMPTY);
  assign rd_match = rd_used && (rd_len == len_r) && (rd_key == key_r) && (rd_val == val_r);

  // Hash operands for the current byte.
  logic [7:0]    cur_byte;
  logic [SW-1:0] h_val;
  logic [DW-1:0] h_ext, s_ext, b_ext;
  logic [SW:0]   loc_sum;
  logic [SW:0]   i_inc;
  logic [32:0]   coll_sum;
  logic          probe_done, cand_hit;
  logic          out_load;

  always_comb begin
    cur_byte = key_r[8*byte_r[2:0] +: 8];
    h_val    = first_r ? '0 : h_rem;
    h_ext    = DW'(h_val);
    s_ext    = DW'(s_rem);
    b_ext    = DW'(cur_byte);
    loc_sum  = {1'b0, loc_r} + {1'b0, step_r};
    i_inc    = {1'b0, i_r} + 1'b1;
  end

  // Probe outcome while the read data of the current slot is present.
  always_comb begin
    if (func_r == FN_INSERT) begin
      cand_hit   = !rd_used;
      probe_done = !rd_used;
    end else begin
      cand_hit   = rd_match;
      probe_done = rd_match || rd_empty;
    end
  end

  assign out_load = (st_r == S_FIN) && (!out_valid_r || !out_stall);

  // Main sequencer.
  always_comb begin
    st_nxt   = st_r;
    h_start  = 1'b0;
    s_start  = 1'b0;
    h_x      = '0;
    s_x      = '0;
    wr_en    = 1'b0;
    wr_addr  = loc_r[AW-1:0];
    wr_data  = {SLOT_USED, len_r, key_r, val_r};
    coll_nxt = coll_r;
    coll_sum = {1'b0, coll_r} + 33'(res_i_r);
    case (st_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = {SLOT_EMPTY, {(MW-2){1'b0}}};
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = (in_func == FN_NONE) ? S_FIN : S_INIT;
        end
      end
      S_INIT: begin
        s_start = 1'b1;
        s_x     = DW'(STEP_SEED);
        st_nxt  = S_HASH;
      end
      S_HASH: begin
        if (!h_busy && !s_busy) begin
          h_start = 1'b1;
          if (byte_r < len_r) begin
            s_start = 1'b1;
            h_x = (hsel_r ? DW'(h_ext * DW'(HASH_MUL_B)) : DW'(h_ext * DW'(HASH_MUL_A))) + b_ext;
            s_x = (s_ext << STEP_SHIFT) + s_ext + b_ext;
          end else begin
            h_x    = hsel_r ? (DW'(HASH_OFFSET) - h_ext) : h_ext;
            st_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (!h_busy) begin
          st_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        st_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (probe_done || (i_inc == {1'b0, t_eff})) begin
          st_nxt = S_FIN;
        end else begin
          st_nxt = S_PROBE;
        end
        if (probe_done && cand_hit && (func_r == FN_INSERT)) begin
          wr_en = 1'b1;
        end else if (probe_done && cand_hit && (func_r == FN_DELETE)) begin
          wr_en   = 1'b1;
          wr_data = {SLOT_DEL, rd_len, rd_key, rd_val};
        end
      end
      S_FIN: begin
        if (out_load) begin
          st_nxt = S_IDLE;
          if (func_r == FN_INSERT) begin
            coll_nxt = coll_sum[32] ? 32'hFFFF_FFFF : coll_sum[31:0];
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      size_r      <= 11'(TABLE_SIZE_RST);
      hsel_r      <= 1'b0;
      coll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      coll_r <= coll_nxt;
      if (st_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && (cfg_index == CFG_TABLE_SIZE)) begin
        size_r <= cfg_data;
      end else if (cfg_valid && (cfg_index == CFG_HASH_SELECT)) begin
        hsel_r <= cfg_data[0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  logic [31:0] slot_ext, cnt_ext;
  assign slot_ext = 32'(res_slot_r);
  assign cnt_ext  = 32'(res_i_r);

  always_ff @(posedge clk) begin
    if ((st_r == S_IDLE) && in_valid) begin
      func_r     <= in_func;
      key_r      <= key_mask;
      len_r      <= len_sat;
      val_r      <= in_value;
      res_hit_r  <= 1'b0;
      res_slot_r <= '0;
      res_i_r    <= '0;
    end
    if (st_r == S_INIT) begin
      byte_r  <= '0;
      first_r <= 1'b1;
    end
    if ((st_r == S_HASH) && !h_busy && !s_busy) begin
      if (byte_r < len_r) begin
        byte_r  <= byte_r + 1'b1;
        first_r <= 1'b0;
      end else begin
        step_r <= s_rem;
      end
    end
    if ((st_r == S_BASE) && !h_busy) begin
      loc_r <= h_rem;
      i_r   <= '0;
    end
    if (st_r == S_CHECK) begin
      res_slot_r <= loc_r;
      res_hit_r  <= probe_done && cand_hit;
      if (probe_done) begin
        res_i_r <= i_r;
      end else begin
        res_i_r <= i_inc[SW-1:0];
        i_r     <= i_inc[SW-1:0];
        loc_r   <= (loc_sum >= {1'b0, t_eff}) ? SW'(loc_sum - {1'b0, t_eff})
                                              : loc_sum[SW-1:0];
      end
    end
    if (out_load) begin
      out_hit_r   <= res_hit_r;
      out_slot_r  <= slot_ext[9:0];
      out_probe_r <= cnt_ext[10:0];
      out_total_r <= coll_nxt;
    end
  end

  assign in_stall            = (st_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_slot            = out_slot_r;
  assign out_probe_count     = out_probe_r;
  assign out_collision_total = out_total_r;

  // A probed slot always lies inside the table in use.
  a_loc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHECK) |-> (loc_r < t_eff))
    else $error("probe slot outside the table");

  // The probe counter never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHECK) |-> (i_r < t_eff))
    else $error("probe count beyond the table size");

  // The collision total only grows.
  a_coll_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (coll_r >= $past(coll_r)))
    else $error("collision total decreased");

  // Both remainder units are idle once the walk starts.
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PROBE) |-> (!h_busy && !s_busy))
    else $error("remainder unit busy during the walk");

endmodule

@@ dv/tb_double_hashing_table_core.sv @@
module tb_double_hashing_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  slot;
    logic [10:0] probes;
    logic [31:0] total;
  } lookup_res_t;

  typedef struct {
    logic [1:0]  fn;
    logic [63:0] key;
    logic [3:0]  len;
    logic [30:0] val;
  } request_t;

  typedef struct {
    row_kind_t   kind;
    request_t    req;
    logic [3:0]  reg_idx;
    logic [10:0] reg_data;
    bit          typed;
    lookup_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [63:0] in_key;
  logic [3:0]  in_key_length;
  logic [30:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  logic [9:0]  out_slot;
  logic [10:0] out_probe_count;
  logic [31:0] out_collision_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [10:0] cfg_data;

  double_hashing_table_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_key              (in_key),
    .in_key_length       (in_key_length),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_probe_count     (out_probe_count),
    .out_collision_total (out_collision_total),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Shadow copy of the table, the collision sum and both registers.
  slot_st_t    tbl_status [DEPTH];
  logic [63:0] tbl_key    [DEPTH];
  logic [3:0]  tbl_len    [DEPTH];
  logic [30:0] tbl_val    [DEPTH];
  logic [31:0] shadow_sum;
  logic [10:0] shadow_size;
  logic        shadow_hsel;

  lookup_res_t pending_results[$];
  request_t    key_pool[$];
  dir_row_t    dir_rows[$];

  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_hits;
  int unsigned n_cfg_writes;
  int unsigned n_errors;
  int unsigned n_full;
  bit          quiet_sender;
  bit          in_done;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Computes the result of one request and applies its effect to the shadow
  // table. The key is masked to its length before hashing and storing, the
  // base hash is reduced after every byte, and the djb2 step is reduced once.
  function automatic lookup_res_t lookup_table(request_t r);
    lookup_res_t      res;
    longint unsigned  t;
    longint unsigned  h;
    longint unsigned  stp;
    longint unsigned  base;
    longint unsigned  sum;
    int unsigned      nbytes;
    int unsigned      i;
    int unsigned      loc;
    int unsigned      last;
    logic [63:0]      mkey;
    logic [7:0]       c;
    bit               found;
    res    = '0;
    found  = 1'b0;
    last   = 0;
    if (r.fn == FN_NONE) begin
      res.total = shadow_sum;
      return res;
    end
    if (shadow_size == 11'd0) t = 64'd1;
    else if (32'(shadow_size) > DEPTH) t = 64'(DEPTH);
    else t = 64'(shadow_size);
    nbytes = (r.len > 4'd8) ? 32'd8 : 32'(r.len);
    mkey = (nbytes == 8) ? r.key : (r.key & ((64'd1 << (8 * nbytes)) - 64'd1));
    h   = 0;
    stp = 64'(STEP_SEED);
    for (int b = 0; b < nbytes; b++) begin
      c   = mkey[8*b +: 8];
      h   = (64'(shadow_hsel ? HASH_MUL_B : HASH_MUL_A) * h + 64'(c)) % t;
      stp = (stp << STEP_SHIFT) + stp + 64'(c);
    end
    base = shadow_hsel ? (64'(HASH_OFFSET) - h) : h;
    stp  = stp % t;
    for (i = 0; i < t; i++) begin
      loc  = 32'((base + stp * 64'(i)) % t);
      last = loc;
      if (r.fn == FN_INSERT) begin
        if (tbl_status[loc] != SLOT_USED) begin
          tbl_status[loc] = SLOT_USED;
          tbl_key[loc]    = mkey;
          tbl_len[loc]    = 4'(nbytes);
          tbl_val[loc]    = r.val;
          found = 1'b1;
          break;
        end
      end else begin
        if (tbl_status[loc] == SLOT_USED && 32'(tbl_len[loc]) == nbytes &&
            tbl_key[loc] == mkey && tbl_val[loc] == r.val) begin
          if (r.fn == FN_DELETE) tbl_status[loc] = SLOT_DEL;
          found = 1'b1;
          break;
        end
        if (tbl_status[loc] == SLOT_EMPTY) break;
      end
    end
    if (r.fn == FN_INSERT) begin
      sum = 64'(shadow_sum) + 64'(i);
      shadow_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
      if (!found) n_full++;
    end
    res.hit    = found;
    res.slot   = 10'(last);
    res.probes = 11'(i);
    res.total  = shadow_sum;
    return res;
  endfunction

  function automatic request_t mk_req(logic [1:0] fn, logic [63:0] key, logic [3:0] len,
                                      logic [30:0] val);
    request_t r;
    r.fn  = fn;
    r.key = key;
    r.len = len;
    r.val = val;
    return r;
  endfunction

  function automatic void add_req(request_t r);
    dir_row_t row;
    row.kind     = ROW_REQ;
    row.req      = r;
    row.reg_idx  = '0;
    row.reg_data = '0;
    row.typed    = 1'b0;
    row.res      = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_checked(request_t r, lookup_res_t res);
    dir_row_t row;
    row.kind     = ROW_REQ;
    row.req      = r;
    row.reg_idx  = '0;
    row.reg_data = '0;
    row.typed    = 1'b1;
    row.res      = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_cfg(logic [3:0] idx, logic [10:0] data);
    dir_row_t row;
    row.kind     = ROW_CFG;
    row.req      = mk_req(FN_INSERT, '0, '0, '0);
    row.reg_idx  = idx;
    row.reg_data = data;
    row.typed    = 1'b0;
    row.res      = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Random gap before a request: none while the sender is quiet, else mostly none,
  // sometimes short and now and then a long pause.
  function automatic int unsigned sender_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (quiet_sender) return 0;
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one request and waits until it is taken. The valid stays high on
  // return, so a back-to-back request only updates the payload.
  task automatic send_request(request_t r, bit typed, lookup_res_t typed_res);
    int unsigned gap;
    lookup_res_t res;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk) begin
      in_valid      <= 1'b1;
      in_func       <= r.fn;
      in_key        <= r.key;
      in_key_length <= r.len;
      in_value      <= r.val;
    end
    do @(posedge clk); while (in_stall);
    res = lookup_table(r);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    n_requests++;
    if (r.fn == FN_INSERT && res.hit && key_pool.size() < 64)
      key_pool.insert(key_pool.size(), r);
  endtask

  // Registers change only when nothing is in flight: the input is dropped,
  // every outstanding result is drained and a short settling time passes.
  task automatic write_reg(logic [3:0] idx, logic [10:0] data);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
    end
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TABLE_SIZE) shadow_size = data;
    else if (idx == CFG_HASH_SELECT) shadow_hsel = data[0];
    n_cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Builds a random request. Most requests insert fresh keys or look up and
  // remove keys that were stored, so that walks run through tombstones and
  // long probe chains; the rest is noise.
  function automatic request_t random_request();
    request_t    r;
    int unsigned p;
    int unsigned q;
    p = $urandom_range(99);
    q = $urandom_range(99);
    r.key = {$urandom, $urandom};
    r.val = 31'($urandom);
    if (q < 85) r.len = 4'($urandom_range(8, 1));
    else r.len = (q < 90) ? 4'd0 : 4'($urandom_range(15, 9));
    if (p < 45) begin
      r.fn = FN_INSERT;
      if (q < 20 && key_pool.size() > 0) r = key_pool[$urandom_range(key_pool.size() - 1)];
      r.fn = FN_INSERT;
    end else if (p < 88 && key_pool.size() > 0) begin
      r = key_pool[$urandom_range(key_pool.size() - 1)];
      r.fn = (p < 70) ? FN_SEARCH : FN_DELETE;
      // A stored key with a different value must not match.
      if (q < 10) r.val = r.val ^ 31'd1;
    end else if (p < 95) begin
      r.fn = (q < 50) ? FN_SEARCH : FN_DELETE;
    end else begin
      r.fn = FN_NONE;
    end
    return r;
  endfunction

  // Stimulus: a directed table first, then random phases under varied
  // table sizes and both hash choices.
  initial begin
    logic [10:0] sizes[14];
    int unsigned count;
    request_t    r;
    lookup_res_t none;
    sizes = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd7, 11'd16, 11'd31, 11'd40,
              11'd64, 11'd100, 11'd255, 11'd1024, 11'd2047};
    none          = '0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FN_INSERT;
    in_key        = '0;
    in_key_length = '0;
    in_value      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TABLE_SIZE;
    cfg_data      = '0;
    in_done       = 1'b0;
    quiet_sender  = 1'b0;
    shadow_sum    = '0;
    shadow_size   = 11'(TABLE_SIZE_RST);
    shadow_hsel   = 1'b0;
    for (int s = 0; s < DEPTH; s++) begin
      tbl_status[s] = SLOT_EMPTY;
      tbl_key[s]    = '0;
      tbl_len[s]    = '0;
      tbl_val[s]    = '0;
    end

    // After reset the empty key hashes to slot 0 with no collision.
    add_checked(mk_req(FN_INSERT, 64'd0, 4'd0, 31'd0), '{1'b1, 10'd0, 11'd0, 32'd0});
    add_checked(mk_req(FN_SEARCH, 64'd0, 4'd0, 31'd0), '{1'b1, 10'd0, 11'd0, 32'd0});
    add_checked(mk_req(FN_NONE, '1, 4'd8, '1), '{1'b0, 10'd0, 11'd0, 32'd0});
    // All-ones key at full length, stored twice, then removed once: the
    // second search must walk past the tombstone to the duplicate.
    add_req(mk_req(FN_INSERT, '1, 4'd8, '1));
    add_req(mk_req(FN_INSERT, '1, 4'd8, '1));
    add_req(mk_req(FN_SEARCH, '1, 4'd8, '1));
    add_req(mk_req(FN_DELETE, '1, 4'd8, '1));
    add_req(mk_req(FN_SEARCH, '1, 4'd8, '1));
    // Overlong lengths saturate at eight bytes.
    add_req(mk_req(FN_INSERT, 64'hDEAD_BEEF_0123_4567, 4'd15, 31'd0));
    add_req(mk_req(FN_INSERT, 64'h8000_0000_0000_0001, 4'd9, 31'h4000_0000));
    // Bytes past the length are ignored, so these two keys are equal.
    add_req(mk_req(FN_INSERT, 64'hFFFF_FFFF_FF00_0102, 4'd3, 31'd5));
    add_req(mk_req(FN_SEARCH, 64'h0000_0000_0000_0102, 4'd3, 31'd5));
    add_req(mk_req(FN_SEARCH, 64'h0000_0000_0000_0102, 4'd3, 31'd6));
    add_req(mk_req(FN_DELETE, 64'h0000_0000_0055_AA33, 4'd4, 31'd9));
    add_cfg(CFG_HASH_SELECT, 11'd1);
    add_req(mk_req(FN_INSERT, 64'h41, 4'd1, 31'd1));
    add_req(mk_req(FN_SEARCH, 64'h41, 4'd1, 31'd1));
    // Size zero acts as one slot, already held by the empty key: full table.
    add_cfg(CFG_TABLE_SIZE, 11'd0);
    add_req(mk_req(FN_INSERT, 64'h77, 4'd2, 31'd3));
    add_req(mk_req(FN_SEARCH, 64'd0, 4'd0, 31'd0));
    add_cfg(CFG_TABLE_SIZE, 11'd2047);
    add_req(mk_req(FN_INSERT, 64'h1234, 4'd2, 31'd7));
    add_cfg(CFG_TABLE_SIZE, 11'd1);
    add_cfg(CFG_HASH_SELECT, 11'd0);
    add_req(mk_req(FN_DELETE, 64'd0, 4'd0, 31'd0));
    add_req(mk_req(FN_INSERT, 64'h99, 4'd1, 31'd2));

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
      else send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
    end

    for (int ph = 0; ph < 14; ph++) begin
      write_reg(CFG_TABLE_SIZE, sizes[$urandom_range(13)]);
      write_reg(CFG_HASH_SELECT, 11'(ph[0]));
      // Every third phase sends without gaps.
      quiet_sender = (ph % 3 == 2);
      count = 73;
      repeat (count) begin
        r = random_request();
        send_request(r, 1'b0, none);
      end
    end
    @(negedge clk) in_valid <= 1'b0;
    in_done = 1'b1;
  end

  // Receiver stall. After the first 150 results it holds off once for a
  // long stretch so that the block fills up and stalls its input.
  initial begin
    int unsigned hold_cnt;
    int unsigned burst;
    bit          held;
    hold_cnt  = 0;
    burst     = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_results >= 150) begin
        held     = 1'b1;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ((n_results / 100) % 4 == 3) begin
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(99) < 2) burst = $urandom_range(50, 15);
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // Compares each accepted result with the oldest pending one.
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result hit=%0d slot=%0d probes=%0d total=%0d", $time,
                 out_hit, out_slot, out_probe_count, out_collision_total);
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.hit) n_hits++;
        if (out_hit !== exp_res.hit) begin
          n_errors++;
          $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, out_hit);
        end
        if (out_slot !== exp_res.slot) begin
          n_errors++;
          $display("%0t: slot expected %0d actual %0d", $time, exp_res.slot, out_slot);
        end
        if (out_probe_count !== exp_res.probes) begin
          n_errors++;
          $display("%0t: probe_count expected %0d actual %0d", $time, exp_res.probes,
                   out_probe_count);
        end
        if (out_collision_total !== exp_res.total) begin
          n_errors++;
          $display("%0t: collision_total expected %0d actual %0d", $time, exp_res.total,
                   out_collision_total);
        end
      end
    end
  end

  // Watchdog: ends the run if no handshake completes for too long. The limit
  // covers the clearing pass, a full-table walk and the long receiver hold.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time, idle,
                 pending_results.size());
        $display("double_hashing_table_core verification failed");
        $finish;
      end
    end
  end

  // End of run: drain, settle, then report.
  initial begin
    wait (in_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d requests (%0d hits, %0d full-table inserts) over %0d register writes.",
             n_requests, n_hits, n_full, n_cfg_writes);
    $display("Checked %0d results, %0d mismatches, final collision total %0d.",
             n_results, n_errors, shadow_sum);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("double_hashing_table_core verification clean");
    end else begin
      $display("double_hashing_table_core verification failed");
    end
    $finish;
  end

endmodule
